@@ src/assert_macros.svh @@
// assertion helpers; clock i_clk and active-low reset i_rst_n must be in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define SPFQ_ASSERT(label, prop) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error("check failed");
`define SPFQ_ASSERT_IMPL(label, ante, cons) \
    `SPFQ_ASSERT(label, (ante) |-> (cons))
`else
`define SPFQ_ASSERT(label, prop)
`define SPFQ_ASSERT_IMPL(label, ante, cons)
`endif
`endif

@@ src/spfq_pkg.sv @@
`default_nettype none
package spfq_pkg;

    localparam int TAG_W   = 16;
    localparam int CLS_W   = 3;
    localparam int REM_W   = 7;
    localparam int MASK_W  = 8;
    localparam int DEPTH_W = 7;

    // command kinds passed from front to back
    localparam logic [1:0] CMD_PUSH   = 2'd0;
    localparam logic [1:0] CMD_REJECT = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;

    typedef struct packed {
        logic [1:0]        kind;
        logic [CLS_W-1:0]  cls;
        logic [TAG_W-1:0]  tag;
        logic [REM_W-1:0]  rem;
        logic [MASK_W-1:0] mask;
    } t_cmd;

endpackage
`default_nettype wire

@@ src/spfq_ifs.sv @@
`default_nettype none
interface spfq_in_if;
    logic        valid;
    logic        ready;
    logic        func;
    logic [3:0]  priority_req;
    logic [15:0] in_tag;
    logic [5:0]  pop_count;
    logic [7:0]  allowed_mask;
    modport source (output valid, func, priority_req, in_tag, pop_count, allowed_mask,
                    input ready);
    modport sink (input valid, func, priority_req, in_tag, pop_count, allowed_mask,
                  output ready);
endinterface

interface spfq_out_if;
    logic        valid;
    logic        ready;
    logic        accepted;
    logic        evicted;
    logic [15:0] evicted_tag;
    logic        frame_valid;
    logic [15:0] out_tag;
    logic [2:0]  out_class;
    logic        last;
    modport source (output valid, accepted, evicted, evicted_tag, frame_valid, out_tag,
                    out_class, last, input ready);
    modport sink (input valid, accepted, evicted, evicted_tag, frame_valid, out_tag,
                  out_class, last, output ready);
endinterface
`default_nettype wire

@@ src/spfq_front.sv @@
`default_nettype none
`include "assert_macros.svh"
module spfq_front #(
    parameter int NUM_CLASSES = 8,
    parameter int MAX_POP     = 32
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    spfq_in_if.sink     i_in,
    output logic        o_cmd_valid,
    output spfq_pkg::t_cmd o_cmd,
    input  wire logic   i_cmd_ready
);

    localparam logic FUNC_POP = 1'b1;
    localparam logic [spfq_pkg::MASK_W-1:0] CLS_MASK =
        spfq_pkg::MASK_W'((1 << NUM_CLASSES) - 1);

    spfq_pkg::t_cmd w_cmd;
    spfq_pkg::t_cmd r_q [2];
    logic           r_wp, r_rp;
    logic [1:0]     r_cnt;
    logic           w_push, w_pop;

    // classify the item
    always_comb begin
        w_cmd      = '0;
        w_cmd.tag  = i_in.in_tag;
        w_cmd.cls  = i_in.priority_req[spfq_pkg::CLS_W-1:0];
        w_cmd.mask = i_in.allowed_mask & CLS_MASK;
        w_cmd.rem  = ({1'b0, i_in.pop_count} > spfq_pkg::REM_W'(MAX_POP))
                   ? spfq_pkg::REM_W'(MAX_POP) : {1'b0, i_in.pop_count};
        if (i_in.func == FUNC_POP) begin
            w_cmd.kind = spfq_pkg::CMD_POP;
        end else if (i_in.priority_req >= 4'(NUM_CLASSES)) begin
            w_cmd.kind = spfq_pkg::CMD_REJECT;
        end else begin
            w_cmd.kind = spfq_pkg::CMD_PUSH;
        end
    end

    assign i_in.ready  = (r_cnt != 2'd2);
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign w_pop       = o_cmd_valid && i_cmd_ready;
    assign o_cmd       = r_q[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(w_push) - 2'(w_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    `SPFQ_ASSERT(a_q_bound, r_cnt <= 2'd2)

endmodule
`default_nettype wire

@@ src/spfq_back.sv @@
`default_nettype none
`include "assert_macros.svh"
module spfq_back #(
    parameter int NUM_CLASSES = 8,
    parameter int CLASS_DEPTH = 64
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [spfq_pkg::DEPTH_W-1:0]  i_max_depth,
    input  wire logic                          i_cmd_valid,
    input  wire spfq_pkg::t_cmd                i_cmd,
    output logic                               o_cmd_ready,
    spfq_out_if.source                         o_out
);

    localparam int CW     = $clog2(NUM_CLASSES);
    localparam int HW     = $clog2(CLASS_DEPTH);
    localparam int FW     = $clog2(CLASS_DEPTH + 1);
    localparam int SW     = HW + 1;
    localparam int NSLOT  = NUM_CLASSES * CLASS_DEPTH;
    localparam int AW     = $clog2(NSLOT);
    localparam int CD_CAP = (CLASS_DEPTH < 127) ? CLASS_DEPTH : 127;
    localparam int DW     = spfq_pkg::DEPTH_W;
    localparam int TW     = spfq_pkg::TAG_W;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_POP  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    logic [1:0]    r_st, n_st;
    logic [FW-1:0] r_fill [NUM_CLASSES];
    logic [HW-1:0] r_head [NUM_CLASSES];
    logic [DW-1:0] r_total;
    logic [TW-1:0] r_mem [NSLOT];
    logic [TW-1:0] r_rdata;

    logic                           r_acc, r_ev, r_fv;
    logic [CW-1:0]                  r_cls;
    logic [spfq_pkg::REM_W-1:0]     r_rem;
    logic [spfq_pkg::MASK_W-1:0]    r_mask;
    logic                           n_acc, n_ev, n_fv;
    logic [CW-1:0]                  n_cls;
    logic [spfq_pkg::REM_W-1:0]     n_rem;
    logic [spfq_pkg::MASK_W-1:0]    n_mask;

    logic                        r_ov, r_o_acc, r_o_ev, r_o_fv, r_o_last;
    logic [TW-1:0]               r_o_etag, r_o_tag;
    logic [spfq_pkg::CLS_W-1:0]  r_o_cls;

    logic [DW-1:0]               w_limit;
    logic                        w_full;
    logic [spfq_pkg::MASK_W-1:0] w_mask;
    logic                        w_pop_found, w_ev_found;
    logic [CW-1:0]               w_pop_cls, w_ev_cls, w_push_cls, w_take_cls;
    logic                        w_take, w_wr, w_free, w_load, w_more;
    logic [AW-1:0]               w_raddr, w_waddr;
    logic [DW-1:0]               w_fill_sum;

    function automatic logic [AW-1:0] slot_addr(input logic [CW-1:0] c,
                                                 input logic [SW-1:0] pos);
        logic [SW-1:0] w;
        w = (pos >= SW'(CLASS_DEPTH)) ? pos - SW'(CLASS_DEPTH) : pos;
        return AW'(c) * AW'(CLASS_DEPTH) + AW'(w);
    endfunction

    assign w_limit    = (i_max_depth > DW'(CD_CAP)) ? DW'(CD_CAP) : i_max_depth;
    assign w_full     = (r_total >= w_limit);
    assign w_mask     = (r_st == S_IDLE) ? i_cmd.mask : r_mask;
    assign w_push_cls = i_cmd.cls[CW-1:0];

    // highest allowed non-empty class
    always_comb begin
        w_pop_found = 1'b0;
        w_pop_cls   = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            if (w_mask[c] && (r_fill[c] != '0)) begin
                w_pop_found = 1'b1;
                w_pop_cls   = CW'(c);
            end
        end
    end

    // lowest non-empty class below the pushed one
    always_comb begin
        w_ev_found = 1'b0;
        w_ev_cls   = '0;
        for (int c = NUM_CLASSES - 1; c >= 0; c--) begin
            if ((3'(c) < i_cmd.cls) && (r_fill[c] != '0)) begin
                w_ev_found = 1'b1;
                w_ev_cls   = CW'(c);
            end
        end
    end

    assign w_free      = !r_ov || o_out.ready;
    assign w_load      = (r_st == S_EMIT) && w_free;
    assign w_more      = (r_rem != '0) && w_pop_found;
    assign o_cmd_ready = (r_st == S_IDLE);

    always_comb begin
        n_st       = r_st;
        n_acc      = r_acc;
        n_ev       = r_ev;
        n_fv       = r_fv;
        n_cls      = r_cls;
        n_rem      = r_rem;
        n_mask     = r_mask;
        w_take     = 1'b0;
        w_take_cls = w_pop_cls;
        w_wr       = 1'b0;
        case (r_st)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_st  = S_EMIT;
                    n_acc = 1'b0;
                    n_ev  = 1'b0;
                    n_fv  = 1'b0;
                    case (i_cmd.kind)
                        spfq_pkg::CMD_PUSH: begin
                            if (!w_full) begin
                                w_wr  = 1'b1;
                                n_acc = 1'b1;
                            end else if (w_ev_found) begin
                                w_wr       = 1'b1;
                                w_take     = 1'b1;
                                w_take_cls = w_ev_cls;
                                n_acc      = 1'b1;
                                n_ev       = 1'b1;
                            end
                        end
                        spfq_pkg::CMD_POP: begin
                            n_mask = i_cmd.mask;
                            n_rem  = '0;
                            if ((i_cmd.rem != '0) && w_pop_found) begin
                                w_take = 1'b1;
                                n_fv   = 1'b1;
                                n_cls  = w_pop_cls;
                                n_rem  = i_cmd.rem - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_POP: begin
                w_take = 1'b1;
                n_fv   = 1'b1;
                n_cls  = w_pop_cls;
                n_rem  = r_rem - 1'b1;
                n_st   = S_EMIT;
            end
            S_EMIT: begin
                if (w_free) begin
                    n_st = (r_fv && w_more) ? S_POP : S_IDLE;
                end
            end
            default: n_st = S_IDLE;
        endcase
    end

    assign w_raddr = slot_addr(w_take_cls, SW'(r_head[w_take_cls]));
    assign w_waddr = slot_addr(w_push_cls,
                               SW'(r_head[w_push_cls]) + SW'(r_fill[w_push_cls]));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st    <= S_IDLE;
            r_total <= '0;
            for (int c = 0; c < NUM_CLASSES; c++) begin
                r_fill[c] <= '0;
                r_head[c] <= '0;
            end
        end else begin
            r_st <= n_st;
            if (w_wr && !w_take) begin
                r_total <= r_total + 1'b1;
            end else if (w_take && !w_wr) begin
                r_total <= r_total - 1'b1;
            end
            for (int c = 0; c < NUM_CLASSES; c++) begin
                if (w_take && (w_take_cls == CW'(c))) begin
                    r_fill[c] <= r_fill[c] - 1'b1;
                    r_head[c] <= (r_head[c] == HW'(CLASS_DEPTH - 1)) ? '0
                               : r_head[c] + 1'b1;
                end else if (w_wr && (w_push_cls == CW'(c))) begin
                    r_fill[c] <= r_fill[c] + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc  <= n_acc;
        r_ev   <= n_ev;
        r_fv   <= n_fv;
        r_cls  <= n_cls;
        r_rem  <= n_rem;
        r_mask <= n_mask;
    end

    // tag store, one write and one registered read a cycle
    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[w_waddr] <= i_cmd.tag;
        end
        if (w_take) begin
            r_rdata <= r_mem[w_raddr];
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else if (w_load) begin
            r_ov <= 1'b1;
        end else if (o_out.ready) begin
            r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_o_acc  <= r_acc;
            r_o_ev   <= r_ev;
            r_o_etag <= r_ev ? r_rdata : '0;
            r_o_fv   <= r_fv;
            r_o_tag  <= r_fv ? r_rdata : '0;
            r_o_cls  <= r_fv ? spfq_pkg::CLS_W'(r_cls) : '0;
            r_o_last <= r_fv ? !w_more : 1'b1;
        end
    end

    assign o_out.valid       = r_ov;
    assign o_out.accepted    = r_o_acc;
    assign o_out.evicted     = r_o_ev;
    assign o_out.evicted_tag = r_o_etag;
    assign o_out.frame_valid = r_o_fv;
    assign o_out.out_tag     = r_o_tag;
    assign o_out.out_class   = r_o_cls;
    assign o_out.last        = r_o_last;

    always_comb begin
        w_fill_sum = '0;
        for (int c = 0; c < NUM_CLASSES; c++) begin
            w_fill_sum = w_fill_sum + DW'(r_fill[c]);
        end
    end

    `SPFQ_ASSERT(a_fill_sum, w_fill_sum == r_total)
    `SPFQ_ASSERT(a_total_cap, r_total <= DW'(CD_CAP))
    `SPFQ_ASSERT_IMPL(a_take_nonempty, w_take, r_fill[w_take_cls] != '0)
    `SPFQ_ASSERT_IMPL(a_evict_lower, w_take && w_wr, 3'(w_take_cls) < i_cmd.cls)

endmodule
`default_nettype wire

@@ src/strict_priority_frame_queue.sv @@
// a first result passes through the command queue, the back-end issue register and the output register in turn
// push, reject and empty pop: the back-end sequencer goes from idle to emit and back, taking no new item until idle
// pop: each frame is issued, read from the tag store and emitted; emit waits while the output is held
// the input side takes items into a 2-entry command queue while the back end works
// reset: synchronous, active low; clears counts and heads, tag store is not cleared
`default_nettype none
module strict_priority_frame_queue #(
    parameter int NUM_CLASSES = 8,
    parameter int CLASS_DEPTH = 64,
    parameter int MAX_POP     = 32
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    spfq_in_if.sink          i_in,
    spfq_out_if.source       o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic [31:0]      prdata,
    output logic             pready
);

    localparam logic [spfq_pkg::DEPTH_W-1:0] MAX_DEPTH_RST = 7'd64;
    // register index taken from the word address bit
    localparam logic REG_MAX_DEPTH = 1'b0;

    logic [spfq_pkg::DEPTH_W-1:0] r_max_depth;
    spfq_pkg::t_cmd               w_cmd;
    logic                         w_cmd_valid, w_cmd_ready;

    // config write completes in the access phase
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_depth <= MAX_DEPTH_RST;
        end else if (psel && penable && pwrite && (paddr[2] == REG_MAX_DEPTH)) begin
            r_max_depth <= pwdata[spfq_pkg::DEPTH_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_MAX_DEPTH) ? 32'(r_max_depth) : 32'd0;

    // front end: classify each item and queue it as a command
    spfq_front #(
        .NUM_CLASSES (NUM_CLASSES),
        .MAX_POP     (MAX_POP)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd),
        .i_cmd_ready (w_cmd_ready)
    );

    // back end: per-class rings in one tag store, eviction and pop streaming
    spfq_back #(
        .NUM_CLASSES (NUM_CLASSES),
        .CLASS_DEPTH (CLASS_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_max_depth (r_max_depth),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_cmd_ready (w_cmd_ready),
        .o_out       (o_out)
    );

endmodule
`default_nettype wire
